// ===== rtl/pkdf_pkg.sv =====
package pkdf_pkg;

    localparam int NumRegs = 5;
    localparam int AddrWidth = 6;
    localparam logic [15:0] RoundCountReset = 16'd10000;

    localparam logic [2:0] RegKeyW0 = 3'd0;
    localparam logic [2:0] RegKeyW1 = 3'd1;
    localparam logic [2:0] RegKeyW2 = 3'd2;
    localparam logic [2:0] RegKeyW3 = 3'd3;
    localparam logic [2:0] RegRounds = 3'd4;

    typedef struct packed {
        logic [63:0] salt_w0;
        logic [63:0] salt_w1;
        logic [63:0] salt_w2;
        logic [63:0] salt_w3;
    } in_item_t;

    typedef struct packed {
        logic [63:0] derived_w0;
        logic [63:0] derived_w1;
        logic [63:0] derived_w2;
        logic [63:0] derived_w3;
    } out_item_t;

    typedef logic [255:0] digest_t;
    typedef logic [511:0] block_t;

    // Sequencer states: idle, the compression jobs it runs, and done
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IPAD,
        ST_OPAD,
        ST_INNER,
        ST_OUTER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    localparam digest_t InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/pbkdf2_key_derivation_unit.sv =====
// PBKDF2-HMAC-SHA256 engine, first 32-byte output block. A 256-bit salt item
// goes in, one 256-bit derived key comes out. The key (registers 0..3, 8-byte
// spaced at 0x00..0x18) and round count (0x20, 0 acts as 1) are written over
// APB; the user must write them only while idle, which the block does not
// enforce. A single SHA-256 round unit does all the work. A compression job
// runs 64 rounds, then the final add, then the done flag, and then the next
// job is launched. An item runs two jobs for the ipad/opad midstates, then
// two per HMAC round. No new item is taken until the result is taken.
module pbkdf2_key_derivation_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pkdf_pkg::AddrWidth-1:0]  paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pkdf_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output pkdf_pkg::out_item_t             out_data
);

    logic [255:0] key;
    logic [15:0] rounds;

    pkdf_pkg::state_t state_reg, state_next;
    pkdf_pkg::digest_t imid_reg, omid_reg, u_reg, acc_reg;
    logic [255:0] salt_reg;
    logic first_reg;
    logic [15:0] left_reg;
    logic go_reg;

    pkdf_pkg::core_ctl_t ctl;
    pkdf_pkg::core_sts_t sts;
    pkdf_pkg::digest_t core_init, digest;
    pkdf_pkg::block_t core_msg;

    assign pready = 1'b1;

    pkdf_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .key(key), .rounds(rounds)
    );

    pkdf_sha_core u_core (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .init_state(core_init), .msg(core_msg),
        .sts(sts), .digest(digest)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pkdf_pkg::ST_IDLE:
                if (in_valid) state_next = pkdf_pkg::ST_IPAD;
            pkdf_pkg::ST_IPAD:
                if (sts.done) state_next = pkdf_pkg::ST_OPAD;
            pkdf_pkg::ST_OPAD:
                if (sts.done) state_next = pkdf_pkg::ST_INNER;
            pkdf_pkg::ST_INNER:
                if (sts.done) state_next = pkdf_pkg::ST_OUTER;
            pkdf_pkg::ST_OUTER:
                if (sts.done)
                    state_next = (left_reg <= 16'd1) ? pkdf_pkg::ST_DONE
                                                     : pkdf_pkg::ST_INNER;
            pkdf_pkg::ST_DONE:
                if (!out_stall) state_next = pkdf_pkg::ST_IDLE;
            default: state_next = pkdf_pkg::ST_IDLE;
        endcase
    end

    // Outputs: core job selection
    always_comb
    begin
        ctl.start = go_reg;
        core_init = pkdf_pkg::InitH;
        core_msg  = '0;
        case (state_reg)
            pkdf_pkg::ST_IPAD:
                core_msg = {key ^ {32{8'h36}}, {32{8'h36}}};
            pkdf_pkg::ST_OPAD:
                core_msg = {key ^ {32{8'h5c}}, {32{8'h5c}}};
            pkdf_pkg::ST_INNER:
            begin
                core_init = imid_reg;
                if (first_reg)
                    core_msg = {salt_reg, 32'd1, 32'h80000000, 160'd0, 32'd800};
                else
                    core_msg = {u_reg, 32'h80000000, 192'd0, 32'd768};
            end
            pkdf_pkg::ST_OUTER:
            begin
                core_init = omid_reg;
                core_msg  = {u_reg, 32'h80000000, 192'd0, 32'd768};
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != pkdf_pkg::ST_IDLE);
    assign out_valid = (state_reg == pkdf_pkg::ST_DONE);
    assign out_data  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pkdf_pkg::ST_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // one start pulse per compression job
            go_reg <= (state_reg == pkdf_pkg::ST_IDLE && in_valid)
                   || (sts.done && state_next != pkdf_pkg::ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pkdf_pkg::ST_IDLE && in_valid)
        begin
            salt_reg  <= in_data;
            first_reg <= 1'b1;
            left_reg  <= (rounds == 16'd0) ? 16'd1 : rounds;
        end
        if (sts.done)
        begin
            case (state_reg)
                pkdf_pkg::ST_IPAD: imid_reg <= digest;
                pkdf_pkg::ST_OPAD: omid_reg <= digest;
                pkdf_pkg::ST_INNER: u_reg <= digest;
                pkdf_pkg::ST_OUTER:
                begin
                    u_reg     <= digest;
                    acc_reg   <= first_reg ? digest : (acc_reg ^ digest);
                    first_reg <= 1'b0;
                    left_reg  <= left_reg - 16'd1;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pkdf_sha_core.sv =====
// One SHA-256 round per cycle; 64 rounds, then the final add.
module pkdf_sha_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pkdf_pkg::core_ctl_t  ctl,
    input  pkdf_pkg::digest_t    init_state,
    input  pkdf_pkg::block_t     msg,
    output pkdf_pkg::core_sts_t  sts,
    output pkdf_pkg::digest_t    digest
);

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    pkdf_pkg::digest_t base_reg;
    pkdf_pkg::digest_t digest_reg;
    logic [5:0] t_reg;
    logic busy_reg;
    logic fin_reg;
    logic done_reg;

    logic [31:0] s0, s1, big0, big1, ch, mj, t1, t2, wnew;

    always_comb
    begin
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
            ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
            ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        big1 = {e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
            ^ {e_reg[24:0], e_reg[31:25]};
        ch = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1 = h_reg + big1 + ch + pkdf_pkg::round_k(t_reg) + w_reg[0];
        big0 = {a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
            ^ {a_reg[21:0], a_reg[31:22]};
        mj = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2 = big0 + mj;
        for (int i = 0; i < 15; i++)
        begin
            w_next[i] = w_reg[i + 1];
        end
        w_next[15] = wnew;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            t_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg && !fin_reg)
            begin
                busy_reg <= 1'b1;
                t_reg    <= '0;
            end
            else if (busy_reg)
            begin
                t_reg <= t_reg + 6'd1;
                if (t_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg && !fin_reg)
        begin
            base_reg <= init_state;
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= init_state;
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= msg[511 - 32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            w_reg <= w_next;
            h_reg <= g_reg;
            g_reg <= f_reg;
            f_reg <= e_reg;
            e_reg <= d_reg + t1;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= a_reg;
            a_reg <= t1 + t2;
        end
        if (fin_reg)
        begin
            digest_reg <= {base_reg[255:224] + a_reg, base_reg[223:192] + b_reg,
                           base_reg[191:160] + c_reg, base_reg[159:128] + d_reg,
                           base_reg[127:96] + e_reg, base_reg[95:64] + f_reg,
                           base_reg[63:32] + g_reg, base_reg[31:0] + h_reg};
        end
    end

    assign sts.busy = busy_reg | fin_reg;
    assign sts.done = done_reg;
    assign digest = digest_reg;

endmodule

// ===== rtl/pkdf_regs.sv =====
// APB register file: four key words and the round count.
module pkdf_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pkdf_pkg::AddrWidth-1:0]  paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic [255:0]                    key,
    output logic [15:0]                     rounds
);

    logic [63:0] key_reg [4];
    logic [15:0] rounds_reg;
    logic [2:0] idx;

    assign idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            rounds_reg <= pkdf_pkg::RoundCountReset;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                pkdf_pkg::RegKeyW0: key_reg[0] <= pwdata;
                pkdf_pkg::RegKeyW1: key_reg[1] <= pwdata;
                pkdf_pkg::RegKeyW2: key_reg[2] <= pwdata;
                pkdf_pkg::RegKeyW3: key_reg[3] <= pwdata;
                pkdf_pkg::RegRounds: rounds_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pkdf_pkg::RegKeyW0: prdata = key_reg[0];
            pkdf_pkg::RegKeyW1: prdata = key_reg[1];
            pkdf_pkg::RegKeyW2: prdata = key_reg[2];
            pkdf_pkg::RegKeyW3: prdata = key_reg[3];
            pkdf_pkg::RegRounds: prdata = {48'd0, rounds_reg};
            default: prdata = '0;
        endcase
    end

    assign key = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    assign rounds = rounds_reg;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    // Register index that decodes to nothing; writes must be dropped
    localparam logic [2:0] RegUnused = 3'd5;
    localparam logic [2:0] RegTop = 3'd7;
    localparam int CycleLimit = 4000000;
    localparam int DrainCycles = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pkdf_pkg::AddrWidth-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    pkdf_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pkdf_pkg::out_item_t out_data;

    pbkdf2_key_derivation_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the register file
    logic [63:0] key_word [4];
    logic [15:0] round_cfg;

    pkdf_pkg::in_item_t salt_queue[$];      // items waiting to be driven
    pkdf_pkg::out_item_t derived_queue[$];  // predicted keys, oldest first
    int errors = 0;
    int mismatches = 0;
    int cycles = 0;

    // ---------------- predictor: SHA-256 / HMAC / PBKDF2 ----------------
    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic pkdf_pkg::digest_t sha_block(pkdf_pkg::digest_t st,
                                                    pkdf_pkg::block_t blk);
        logic [31:0] w [64];
        logic [31:0] h [8];
        logic [31:0] a, b, c, d, e, f, g, hh, s0, s1, t1, t2;
        pkdf_pkg::digest_t res;
        for (int t = 0; t < 16; t++)
            w[t] = blk[511 - 32 * t -: 32];
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            h[i] = st[255 - 32 * i -: 32];
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + pkdf_pkg::round_k(t[5:0]) + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        res = {h[0] + a, h[1] + b, h[2] + c, h[3] + d,
               h[4] + e, h[5] + f, h[6] + g, h[7] + hh};
        return res;
    endfunction

    // Hash of a 32-byte prior digest, on top of a pad midstate
    function automatic pkdf_pkg::digest_t sha_tail32(pkdf_pkg::digest_t mid,
                                                     pkdf_pkg::digest_t msg);
        return sha_block(mid, {msg, 32'h80000000, 192'h0, 32'd768});
    endfunction

    function automatic pkdf_pkg::out_item_t derive_key(pkdf_pkg::in_item_t salt);
        pkdf_pkg::digest_t key, imid, omid, u, acc;
        int n;
        key = {key_word[0], key_word[1], key_word[2], key_word[3]};
        imid = sha_block(pkdf_pkg::InitH, {key, 256'h0} ^ {16{32'h36363636}});
        omid = sha_block(pkdf_pkg::InitH, {key, 256'h0} ^ {16{32'h5c5c5c5c}});
        // first round: salt followed by block index 1
        u = sha_block(imid, {salt, 32'h1, 32'h80000000, 160'h0, 32'd800});
        u = sha_tail32(omid, u);
        acc = u;
        n = (round_cfg == 16'd0) ? 1 : int'(round_cfg);
        for (int r = 1; r < n; r++)
        begin
            u = sha_tail32(omid, sha_tail32(imid, u));
            acc ^= u;
        end
        return pkdf_pkg::out_item_t'(acc);
    endfunction

    // ---------------- idle-gap shaping ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ---------------- driver ----------------
    int in_gap = 0;
    int in_burst = 0;   // items left to send back to back

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            logic busy;
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                derived_queue.push_back(derive_key(in_data));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (salt_queue.size() > 0)
                begin
                    in_data <= salt_queue.pop_front();
                    in_valid <= 1'b1;
                    if (in_burst > 0)
                        in_burst--;
                    else if ($urandom_range(0, 9) == 0)
                        in_burst = $urandom_range(3, 8);
                    else
                        in_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor / checker ----------------
    int out_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            pkdf_pkg::out_item_t want;
            if (out_valid && !out_stall)
            begin
                if (derived_queue.size() == 0)
                begin
                    errors++;
                    $display("unexpected item: %h", out_data);
                end
                else
                begin
                    want = derived_queue.pop_front();
                    if (want != out_data)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            if (want.derived_w0 != out_data.derived_w0)
                                $display("derived_w0 exp %h got %h",
                                         want.derived_w0, out_data.derived_w0);
                            if (want.derived_w1 != out_data.derived_w1)
                                $display("derived_w1 exp %h got %h",
                                         want.derived_w1, out_data.derived_w1);
                            if (want.derived_w2 != out_data.derived_w2)
                                $display("derived_w2 exp %h got %h",
                                         want.derived_w2, out_data.derived_w2);
                            if (want.derived_w3 != out_data.derived_w3)
                                $display("derived_w3 exp %h got %h",
                                         want.derived_w3, out_data.derived_w3);
                        end
                    end
                end
            end
            // stall pattern: runs of free cycles broken by short or long holds
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_hold = pick_gap();
                out_stall <= (out_hold > 0);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------- timeout ----------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- register access ----------------
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= pkdf_pkg::RegKeyW3)
            key_word[idx[1:0]] = val;
        else if (idx == pkdf_pkg::RegRounds)
            round_cfg = val[15:0];
    endtask

    task automatic set_key(logic [255:0] k);
        reg_write(pkdf_pkg::RegKeyW0, k[255:192]);
        reg_write(pkdf_pkg::RegKeyW1, k[191:128]);
        reg_write(pkdf_pkg::RegKeyW2, k[127:64]);
        reg_write(pkdf_pkg::RegKeyW3, k[63:0]);
    endtask

    // Block is idle once all items are in and every result has been taken;
    // checked between edges so driver and monitor updates have settled
    task automatic wait_idle();
        while (salt_queue.size() != 0 || in_valid || derived_queue.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [255:0] rand256();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // ---------------- sequence ----------------
    initial
    begin
        for (int i = 0; i < 4; i++)
            key_word[i] = '0;
        round_cfg = pkdf_pkg::RoundCountReset;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: zero key, one round, salt extremes
        set_key('0);
        reg_write(pkdf_pkg::RegRounds, 64'd1);
        salt_queue.push_back('0);
        salt_queue.push_back('1);
        salt_queue.push_back({64'h8000000000000001, 64'h0123456789abcdef,
                              64'hfedcba9876543210, 64'h7ffffffffffffffe});
        wait_idle();

        // all-ones key, zero round count behaves as a single round
        set_key('1);
        reg_write(pkdf_pkg::RegRounds, 64'd0);
        salt_queue.push_back('0);
        salt_queue.push_back('1);
        wait_idle();

        // over-wide count keeps only the low 16 bits (here zero)
        reg_write(pkdf_pkg::RegRounds, 64'hffffffffffff0000);
        salt_queue.push_back(rand256());
        wait_idle();

        // writes to undecoded slots change nothing
        reg_write(pkdf_pkg::RegRounds, 64'd2);
        reg_write(RegUnused, '1);
        reg_write(RegTop, '1);
        salt_queue.push_back(rand256());
        salt_queue.push_back('1);
        wait_idle();

        // longer iteration chains
        set_key(rand256());
        reg_write(pkdf_pkg::RegRounds, 64'd1500);
        salt_queue.push_back(rand256());
        wait_idle();
        reg_write(pkdf_pkg::RegRounds, 64'd3);
        for (int i = 0; i < 4; i++)
            salt_queue.push_back(rand256());
        wait_idle();

        // random phases: fresh key and small count each time
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 3))
                0: set_key('0);
                1: set_key('1);
                default: set_key(rand256());
            endcase
            reg_write(pkdf_pkg::RegRounds,
                      {$urandom, $urandom_range(0, 5)} & 64'hffff_ffff_0000_0007);
            for (int i = 0; i < 9; i++)
                salt_queue.push_back(rand256());
            wait_idle();
        end

        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
